>>> rtl/hls_pkg.sv
// Package for the host label splitter: constants, codes, state and result types,
// and the label classification functions. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package hls_pkg;

   localparam int MAX_DOTS = 7;
   localparam int DOT_W = $clog2(MAX_DOTS + 2);
   localparam int COUNTRY_NUM = 12;
   localparam int GENERIC_NUM = 6;

   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [23:0] HEAD_COM = 24'h636f6d;
   localparam logic [23:0] HEAD_CN = 24'h636e00;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_EDGE = 3'd1;
   localparam logic [2:0] STATUS_MANY_DOTS = 3'd2;
   localparam logic [2:0] STATUS_NO_DOT = 3'd3;
   localparam logic [2:0] STATUS_EMPTY = 3'd4;

   localparam logic [1:0] SEL_COM = 2'd0;
   localparam logic [1:0] SEL_CN = 2'd1;
   localparam logic [1:0] SEL_COM_CN = 2'd2;
   localparam logic [1:0] SEL_NONE = 2'd3;

   localparam logic [15:0] COUNTRY_HEADS [COUNTRY_NUM] = '{
      16'h636e, 16'h7573, 16'h756b, 16'h6b72, 16'h6a70, 16'h6575,
      16'h6672, 16'h686b, 16'h7477, 16'h696f, 16'h6974, 16'h6d6f
   };
   localparam logic [23:0] GENERIC_HEADS [GENERIC_NUM] = '{
      24'h636f6d, 24'h6e6574, 24'h6f7267, 24'h676f76, 24'h656475, 24'h62697a
   };

   typedef struct packed {
      logic [7:0]       byte_count;
      logic [DOT_W-1:0] dot_count;
      logic             first_was_dot;
      logic             prev_was_dot;
      logic             empty_seen;
      logic [7:0]       cur_len;
      logic [23:0]      cur_head;
      logic [7:0]       prev_len;
      logic [23:0]      prev_head;
      logic [7:0]       prev2_len;
      logic [7:0]       star_flags;
   } hls_state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] label_total;
      logic       merged;
      logic [1:0] table_select;
      logic [7:0] top_label_len;
      logic [7:0] key_label_len;
      logic [7:0] wildcard_mask;
   } hls_result_type;

   function automatic logic is_star(input logic [7:0] len, input logic [23:0] head);
      return (len == 8'd1) && (head[23:16] == CHAR_STAR);
   endfunction

   function automatic logic is_country(input logic [7:0] len, input logic [23:0] head);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < COUNTRY_NUM; i++) begin
         if (head == {COUNTRY_HEADS[i], 8'h00}) hit = 1'b1;
      end
      return (len == 8'd2) && hit;
   endfunction

   function automatic logic is_generic(input logic [7:0] len, input logic [23:0] head);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < GENERIC_NUM; i++) begin
         if (head == GENERIC_HEADS[i]) hit = 1'b1;
      end
      return (len == 8'd3) && hit;
   endfunction

endpackage
`default_nettype wire

>>> rtl/hls_req_if.sv
// Input channel of the host label splitter: valid, ready, one name byte and a last-byte flag.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
interface hls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] host_byte;
   logic       last_byte;

   modport source (output valid, output host_byte, output last_byte, input ready);
   modport sink (input valid, input host_byte, input last_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/hls_rsp_if.sv
// Result channel of the host label splitter: valid, ready and the split result.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
interface hls_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [3:0] label_total;
   logic       merged;
   logic [1:0] table_select;
   logic [7:0] top_label_len;
   logic [7:0] key_label_len;
   logic [7:0] wildcard_mask;

   modport source (output valid, output status, output label_total, output merged,
                   output table_select, output top_label_len, output key_label_len,
                   output wildcard_mask, input ready);
   modport sink (input valid, input status, input label_total, input merged,
                 input table_select, input top_label_len, input key_label_len,
                 input wildcard_mask, output ready);
endinterface
`default_nettype wire

>>> rtl/hls_scan.sv
// Running scan state of the host label splitter, updated once per accepted byte.
// It depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hls_scan (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            host_byte,
   input  wire logic                  last_byte,
   output hls_pkg::hls_state_type     state_next,
   output logic                       dot_seen
);
   import hls_pkg::*;

   hls_state_type state_ff;
   hls_state_type state_in;

   assign dot_seen = (host_byte == CHAR_DOT);
   assign state_next = state_in;

   always_comb begin
      state_in = state_ff;
      if (dot_seen) begin
         if (state_ff.byte_count == 8'd0) state_in.first_was_dot = 1'b1;
         if (state_ff.prev_was_dot) state_in.empty_seen = 1'b1;
         state_in.star_flags = {state_ff.star_flags[6:0],
                                is_star(state_ff.cur_len, state_ff.cur_head)};
         state_in.prev2_len = state_ff.prev_len;
         state_in.prev_len = state_ff.cur_len;
         state_in.prev_head = state_ff.cur_head;
         state_in.cur_len = 8'd0;
         state_in.cur_head = 24'd0;
         if (state_ff.dot_count <= DOT_W'(MAX_DOTS)) begin
            state_in.dot_count = state_ff.dot_count + 1'b1;
         end
      end else begin
         if (state_ff.cur_len < 8'd3) begin
            case (state_ff.cur_len[1:0])
               2'd0: state_in.cur_head[23:16] = host_byte;
               2'd1: state_in.cur_head[15:8] = host_byte;
               default: state_in.cur_head[7:0] = host_byte;
            endcase
         end
         if (state_ff.cur_len != 8'd255) state_in.cur_len = state_ff.cur_len + 8'd1;
      end
      state_in.prev_was_dot = dot_seen;
      if (state_ff.byte_count != 8'd255) state_in.byte_count = state_ff.byte_count + 8'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= last_byte ? '0 : state_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/hls_classify.sv
// Checks and classification of a completed host name from its final scan state.
// It depends on hls_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hls_classify (
   input  wire hls_pkg::hls_state_type state,
   input  wire logic                   dot_seen,
   output hls_pkg::hls_result_type     result
);
   import hls_pkg::*;

   logic [2:0]     status;
   logic           cur_star;
   logic           do_merge;
   logic [DOT_W:0] count_plus;

   assign cur_star = is_star(state.cur_len, state.cur_head);
   assign do_merge = is_country(state.cur_len, state.cur_head)
                     && is_generic(state.prev_len, state.prev_head);
   assign count_plus = {1'b0, state.dot_count} + 1'b1;

   always_comb begin
      if (state.byte_count < 8'd3 || state.first_was_dot || dot_seen) begin
         status = STATUS_EDGE;
      end else if (state.dot_count > DOT_W'(MAX_DOTS)) begin
         status = STATUS_MANY_DOTS;
      end else if (state.dot_count == '0) begin
         status = STATUS_NO_DOT;
      end else if (state.empty_seen) begin
         status = STATUS_EMPTY;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      result = '0;
      result.status = status;
      result.table_select = SEL_NONE;
      if (status == STATUS_OK) begin
         if (do_merge) begin
            result.merged = 1'b1;
            result.label_total = 4'(state.dot_count);
            result.top_label_len = 8'd6;
            result.key_label_len = state.prev2_len;
            result.wildcard_mask = state.star_flags;
            if (state.cur_head == HEAD_CN && state.prev_head == HEAD_COM) begin
               result.table_select = SEL_COM_CN;
            end
         end else begin
            result.label_total = 4'(count_plus);
            result.top_label_len = state.cur_len;
            result.key_label_len = state.prev_len;
            result.wildcard_mask = {state.star_flags[6:0], cur_star};
            if (state.cur_len == 8'd3 && state.cur_head == HEAD_COM) begin
               result.table_select = SEL_COM;
            end else if (state.cur_len == 8'd2 && state.cur_head == HEAD_CN) begin
               result.table_select = SEL_CN;
            end
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/host_label_splitter.sv
// Top level of the host label splitter: byte scan, classification, result register.
// It depends on hls_pkg, hls_req_if, hls_rsp_if, hls_scan and hls_classify.
//
//   channel   direction  moves per transaction
//   req_chan  in         host_byte, last_byte
//   rsp_chan  out        status, counts, merge flag, table select, lengths, mask
//
// One byte is taken per cycle while req_chan ready is high; the result of a name is
// registered at the edge that accepts its last byte and shows on rsp_chan in the
// next cycle. Reset clears the scan state and the result valid flag; the state also
// clears after every last byte. While a result waits unaccepted, req_chan ready is
// low for every byte; it is high again in the cycle that the result is taken.
`timescale 1ns / 1ps
`default_nettype none
module host_label_splitter (
   input wire logic clock,
   input wire logic reset,
   hls_req_if.sink   req_chan,
   hls_rsp_if.source rsp_chan
);
   import hls_pkg::*;

   hls_state_type  state_next;
   hls_result_type result;
   hls_result_type rsp_data_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           dot_seen;
   logic           accept;
   logic           finish;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign finish = accept && req_chan.last_byte;

   hls_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .host_byte  (req_chan.host_byte),
      .last_byte  (req_chan.last_byte),
      .state_next (state_next),
      .dot_seen   (dot_seen)
   );

   hls_classify u_classify (
      .state    (state_next),
      .dot_seen (dot_seen),
      .result   (result)
   );

   assign rsp_valid_in = finish ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_data_ff.status;
   assign rsp_chan.label_total = rsp_data_ff.label_total;
   assign rsp_chan.merged = rsp_data_ff.merged;
   assign rsp_chan.table_select = rsp_data_ff.table_select;
   assign rsp_chan.top_label_len = rsp_data_ff.top_label_len;
   assign rsp_chan.key_label_len = rsp_data_ff.key_label_len;
   assign rsp_chan.wildcard_mask = rsp_data_ff.wildcard_mask;

endmodule
`default_nettype wire

>>> sim/host_label_splitter_test.sv
// Self-checking testbench for host_label_splitter: drives host names byte by byte and
// checks every split result against a predictor kept inside this module.
// Depends on hls_pkg, hls_req_if, hls_rsp_if and the host_label_splitter RTL.
`timescale 1ns / 1ps
module host_label_splitter_test;
   import hls_pkg::*;

   localparam logic [7:0] DOT = 8'h2E;
   localparam logic [7:0] STAR = 8'h2A;
   localparam logic [23:0] COM_HEAD = 24'h636f6d;
   localparam logic [23:0] CN_HEAD = 24'h636e00;
   localparam int HOLD_CYCLES = 200;

   localparam logic [15:0] CC_CODES [12] = '{
      16'h636e, 16'h7573, 16'h756b, 16'h6b72, 16'h6a70, 16'h6575,
      16'h6672, 16'h686b, 16'h7477, 16'h696f, 16'h6974, 16'h6d6f
   };
   localparam logic [23:0] GENERIC_CODES [6] = '{
      24'h636f6d, 24'h6e6574, 24'h6f7267, 24'h676f76, 24'h656475, 24'h62697a
   };

   string cc_names [12] = '{"cn", "us", "uk", "kr", "jp", "eu",
                            "fr", "hk", "tw", "io", "it", "mo"};
   string generic_names [6] = '{"com", "net", "org", "gov", "edu", "biz"};

   typedef struct packed {
      logic [7:0]  seen;
      logic [3:0]  dots;
      logic        lead_dot;
      logic        after_dot;
      logic        gap_found;
      logic [7:0]  top_len;
      logic [23:0] top_head;
      logic [7:0]  next_len;
      logic [23:0] next_head;
      logic [7:0]  third_len;
      logic [7:0]  stars;
   } scan_state_type;

   typedef struct {
      logic [7:0] value;
      logic       fin;
      bit         drain;
   } host_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hls_req_if req_bus ();
   hls_rsp_if rsp_bus ();

   host_label_splitter u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   scan_state_type scan;
   hls_result_type expected_splits [$];
   hls_result_type want_split;
   host_item_type  host_bytes [$];
   host_item_type  next_item;
   logic [7:0]     name_buf [$];

   int fail_count = 0;
   int names_queued = 0;
   int bytes_shown = 0;
   int bytes_taken = 0;
   int results_seen = 0;
   int ok_count = 0;
   int merged_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int rx_cycle = 0;
   int hold_left = 0;
   int holds_done = 0;

   function automatic bit lone_star(logic [7:0] len, logic [23:0] head);
      return len == 8'd1 && head[23:16] == STAR;
   endfunction

   function automatic bit is_cc_label(logic [7:0] len, logic [23:0] head);
      bit hit;
      hit = 1'b0;
      foreach (CC_CODES[i]) if (head == {CC_CODES[i], 8'h00}) hit = 1'b1;
      return len == 8'd2 && hit;
   endfunction

   function automatic bit is_generic_label(logic [7:0] len, logic [23:0] head);
      bit hit;
      hit = 1'b0;
      foreach (GENERIC_CODES[i]) if (head == GENERIC_CODES[i]) hit = 1'b1;
      return len == 8'd3 && hit;
   endfunction

   // Advances the label scan by one accepted byte and, on the last byte of a name,
   // queues the split result that the block must return.
   function void scan_byte(logic [7:0] value, logic fin);
      hls_result_type r;
      logic [7:0] flags;
      logic is_dot;
      is_dot = (value == DOT);
      if (is_dot) begin
         if (scan.seen == 8'd0) scan.lead_dot = 1'b1;
         if (scan.after_dot) scan.gap_found = 1'b1;
         scan.stars = {scan.stars[6:0], lone_star(scan.top_len, scan.top_head)};
         scan.third_len = scan.next_len;
         scan.next_len = scan.top_len;
         scan.next_head = scan.top_head;
         scan.top_len = 8'd0;
         scan.top_head = 24'd0;
         if (scan.dots <= MAX_DOTS) scan.dots = scan.dots + 4'd1;
      end else begin
         case (scan.top_len)
            8'd0: scan.top_head[23:16] = value;
            8'd1: scan.top_head[15:8] = value;
            8'd2: scan.top_head[7:0] = value;
            default: ;
         endcase
         if (scan.top_len != 8'hFF) scan.top_len = scan.top_len + 8'd1;
      end
      scan.after_dot = is_dot;
      if (scan.seen != 8'hFF) scan.seen = scan.seen + 8'd1;
      if (!fin) return;

      r = '0;
      r.table_select = SEL_NONE;
      if (scan.seen < 8'd3 || scan.lead_dot || is_dot) r.status = STATUS_EDGE;
      else if (scan.dots > MAX_DOTS) r.status = STATUS_MANY_DOTS;
      else if (scan.dots == 4'd0) r.status = STATUS_NO_DOT;
      else if (scan.gap_found) r.status = STATUS_EMPTY;
      else r.status = STATUS_OK;

      if (r.status == STATUS_OK) begin
         flags = {scan.stars[6:0], lone_star(scan.top_len, scan.top_head)};
         r.merged = is_cc_label(scan.top_len, scan.top_head)
                    && is_generic_label(scan.next_len, scan.next_head);
         if (r.merged) begin
            r.label_total = scan.dots;
            r.top_label_len = 8'd6;
            r.key_label_len = scan.third_len;
            r.wildcard_mask = scan.stars;
            if (scan.top_head == CN_HEAD && scan.next_head == COM_HEAD)
               r.table_select = SEL_COM_CN;
         end else begin
            r.label_total = scan.dots + 4'd1;
            r.top_label_len = scan.top_len;
            r.key_label_len = scan.next_len;
            r.wildcard_mask = flags;
            if (scan.top_len == 8'd3 && scan.top_head == COM_HEAD) r.table_select = SEL_COM;
            else if (scan.top_len == 8'd2 && scan.top_head == CN_HEAD) r.table_select = SEL_CN;
         end
      end
      expected_splits.push_back(r);
      scan = '0;
   endfunction

   task automatic check_field(input string field, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
   endtask

   task automatic add_byte(input logic [7:0] value);
      name_buf.push_back(value);
   endtask

   task automatic end_name(input bit drain_first);
      host_item_type it;
      foreach (name_buf[i]) begin
         it.value = name_buf[i];
         it.fin = (i == name_buf.size() - 1);
         it.drain = drain_first && (i == 0);
         host_bytes.push_back(it);
      end
      name_buf.delete();
      names_queued++;
   endtask

   function automatic logic [7:0] any_label_byte();
      logic [7:0] v;
      v = 8'($urandom_range(0, 255));
      if (v == DOT) v = 8'h2D;
      return v;
   endfunction

   task automatic add_random_label();
      int pick;
      int n;
      pick = $urandom_range(0, 19);
      if (pick < 3) add_text("*");
      else if (pick < 6) add_text(cc_names[$urandom_range(0, 11)]);
      else if (pick < 9) add_text(generic_names[$urandom_range(0, 5)]);
      else begin
         n = $urandom_range(1, 5);
         repeat (n) add_byte(pick < 16 ? 8'(8'h61 + $urandom_range(0, 25)) : any_label_byte());
      end
   endtask

   // Mostly well-formed names with a random top; some with too many dots, some
   // damaged at an edge or by a doubled dot, and some pure noise.
   task automatic add_random_name(input bit drain_first);
      int kind;
      int nlab;
      int tail;
      int at;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         nlab = $urandom_range(1, 12);
         repeat (nlab) begin
            if ($urandom_range(0, 3) == 0) add_byte(DOT);
            else add_byte(any_label_byte());
         end
      end else begin
         nlab = (kind == 1) ? $urandom_range(9, 17) : $urandom_range(1, 8);
         tail = $urandom_range(0, 9);
         for (int i = 0; i < nlab; i++) begin
            if (i > 0) add_byte(DOT);
            if (tail < 4 && i == nlab - 2) add_text(generic_names[$urandom_range(0, 5)]);
            else if (tail < 4 && i == nlab - 1) add_text(cc_names[$urandom_range(0, 11)]);
            else if (tail == 4 && i == nlab - 1) add_text("com");
            else if (tail == 5 && i == nlab - 1) add_text("cn");
            else add_random_label();
         end
         if (kind == 2) begin
            case ($urandom_range(0, 2))
               0: name_buf.push_front(DOT);
               1: name_buf.push_back(DOT);
               default: begin
                  at = -1;
                  foreach (name_buf[i]) if (at < 0 && name_buf[i] == DOT) at = i;
                  if (at < 0) name_buf.push_back(DOT);
                  else name_buf.insert(at, DOT);
               end
            endcase
         end
      end
      end_name(drain_first);
   endtask

   // Sender: bursts of transactions separated by gaps, holding each byte until taken.
   always @(negedge clock) begin
      if (!reset && bytes_shown == bytes_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (host_bytes.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (host_bytes[0].drain && expected_splits.size() != 0) begin
            req_bus.valid <= 1'b0;
         end else begin
            next_item = host_bytes.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.host_byte <= next_item.value;
            req_bus.last_byte <= next_item.fin;
            bytes_shown++;
            if (burst_left <= 1) begin
               if ($urandom_range(0, 5) == 0) begin
                  burst_left = $urandom_range(30, 80);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 10);
                  gap_left = $urandom_range(1, 8);
               end
            end else begin
               burst_left--;
            end
         end
      end
   end

   // Receiver: a stall pattern that rotates among four modes, plus two long holds.
   always @(negedge clock) begin
      if (!reset) begin
         rx_cycle++;
         if (hold_left == 0 && ((holds_done == 0 && results_seen >= 6)
                                || (holds_done == 1 && results_seen >= 25))) begin
            hold_left = HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 97) % 4)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= (rx_cycle % 5 == 0);
               default: rsp_bus.ready <= (rx_cycle % 3 != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (expected_splits.size() == 0) begin
               $error("result transaction with no host name pending");
               fail_count++;
            end else begin
               want_split = expected_splits.pop_front();
               check_field("status", want_split.status, rsp_bus.status);
               check_field("label_total", want_split.label_total, rsp_bus.label_total);
               check_field("merged", want_split.merged, rsp_bus.merged);
               check_field("table_select", want_split.table_select, rsp_bus.table_select);
               check_field("top_label_len", want_split.top_label_len, rsp_bus.top_label_len);
               check_field("key_label_len", want_split.key_label_len, rsp_bus.key_label_len);
               check_field("wildcard_mask", want_split.wildcard_mask, rsp_bus.wildcard_mask);
               if (want_split.status == STATUS_OK) ok_count++;
               if (want_split.merged) merged_count++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            scan_byte(req_bus.host_byte, req_bus.last_byte);
            bytes_taken++;
         end
      end
   end

   initial begin
      #1_000_000;
      $display("host_label_splitter verification failed");
      $finish;
   end

   initial begin
      int random_start;
      int names_start;
      bit mid_drain_done;
      bit drain_now;

      req_bus.valid = 1'b0;
      req_bus.host_byte = 8'h00;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready = 1'b0;
      scan = '0;
      mid_drain_done = 1'b0;

      add_text("a.b");            end_name(1'b0);
      add_text("ab");             end_name(1'b0);
      add_text(".ab");            end_name(1'b0);
      add_text("ab.");            end_name(1'b0);
      add_text(".");              end_name(1'b0);
      add_text("abc");            end_name(1'b0);
      add_text("a..b");           end_name(1'b0);
      add_text(".b..c");          end_name(1'b0);
      add_text("*.b.*.d.e.f.g.*"); end_name(1'b0);
      add_text("a.b.c.d.e.f.g.h.i"); end_name(1'b0);
      add_text("a");
      repeat (15) add_text(".x");
      end_name(1'b0);
      add_text("x.com.cn");       end_name(1'b0);
      add_text("com.cn");         end_name(1'b0);
      add_text("*.*.net.uk");     end_name(1'b0);
      add_text("a.com");          end_name(1'b0);
      add_text("a.cn");           end_name(1'b0);
      add_text("b.com.us");       end_name(1'b0);
      add_text("a.co.cn");        end_name(1'b0);
      add_text("cn.com");         end_name(1'b0);
      add_text("**.a.*");         end_name(1'b0);
      add_byte(8'h00);
      add_text(".");
      add_byte(8'hFF);
      add_byte(8'h00);
      end_name(1'b0);
      add_text("r.");
      repeat (256) add_byte(8'h71);
      end_name(1'b0);

      random_start = host_bytes.size();
      names_start = names_queued;
      add_random_name(1'b1);
      while (host_bytes.size() < random_start + 200 || names_queued < names_start + 15) begin
         drain_now = !mid_drain_done && host_bytes.size() >= random_start + 100;
         if (drain_now) mid_drain_done = 1'b1;
         add_random_name(drain_now);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (host_bytes.size() != 0 || bytes_shown != bytes_taken || expected_splits.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d host names in %0d bytes; %0d results checked, %0d split ok, %0d merged.",
               names_queued, bytes_taken, results_seen, ok_count, merged_count);
      if (fail_count == 0) begin
         $display("host_label_splitter verification clean");
      end else begin
         $display("host_label_splitter verification failed");
      end
      $finish;
   end

endmodule
